/* hw/rtl/partition_counting_sort_defines.svh */
// assertion macros for the partition counting sort block
`ifndef PARTITION_COUNTING_SORT_DEFINES_SVH
`define PARTITION_COUNTING_SORT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define PCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define PCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/pcs_pkg.sv */
// shared types and constants of the partition counting sort block
package pcs_pkg;

  localparam int unsigned MAX_ROWS  = 4096;
  localparam int unsigned MAX_PARTS = 256;

  localparam int unsigned ROW_AW    = $clog2(MAX_ROWS);
  localparam int unsigned CNT_W     = $clog2(MAX_ROWS + 1);
  localparam int unsigned BKT_DEPTH = MAX_PARTS + 1;
  localparam int unsigned BKT_AW    = $clog2(BKT_DEPTH);
  localparam int unsigned ID_W      = 8;
  localparam int unsigned PC_W      = 9;
  localparam int unsigned IDX_W     = 13;
  localparam int unsigned VAL_W     = 13;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_GROUPED = 2'd1;
  localparam logic [1:0] FUNC_START   = 2'd2;
  localparam logic [1:0] FUNC_SOURCE  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_NA    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_DIS  = 1'b1;

  typedef struct packed {
    logic [1:0]       func;
    logic [ID_W-1:0]  partition_id;
    logic             last_row;
    logic [IDX_W-1:0] index;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [1:0]       status;
  } out_t;

  typedef struct packed {
    logic              clear;
    logic              we;
    logic [BKT_AW-1:0] waddr;
    logic [CNT_W-1:0]  wdata;
    logic [BKT_AW-1:0] raddr;
  } bkt_req_t;

endpackage

/* hw/rtl/pcs_ram.sv */
// generic simple dual-port ram with registered read
module pcs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/pcs_bucket.sv */
// bucket count table: ram plus per-entry valid bits that all clear at once
module pcs_bucket import pcs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bkt_req_t         req_i,
  output logic [CNT_W-1:0] rdata_o
);

  logic [BKT_DEPTH-1:0] valid_q;
  logic                 rvalid_q;
  logic [CNT_W-1:0]     ram_rdata;

  pcs_ram #(
    .Width(CNT_W),
    .Depth(BKT_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (req_i.we),
    .waddr_i(req_i.waddr),
    .wdata_i(req_i.wdata),
    .raddr_i(req_i.raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        valid_q <= '0;
      end
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      rvalid_q <= valid_q[req_i.raddr] & ~req_i.clear;
    end
  end

  // unwritten entries read as zero
  assign rdata_o = rvalid_q ? ram_rdata : '0;

endmodule

/* hw/rtl/partition_counting_sort.sv */
// top level of the partition counting sort block
// Groups a batch of rows by partition id with a stable counting sort. A load
// item does one bucket read-modify-write on the bucket ram. A read item does
// one registered ram read; its result, like that of an item answered from
// status alone, passes the pending slot first. Unless grouping is disabled,
// the item marking the last row also runs the grouping pass before the next
// item is taken: a prefix sum over MAX_PARTS + 1 buckets and a scatter of the
// loaded rows, both paced by the single read port of the bucket ram and the
// chain source id -> bucket -> grouped row. A finished result sits in a
// pending slot and an output register, so one more item can be taken while
// the output is stalled. Bucket entries carry valid bits, so there is no
// clearing pass after reset or between batches.
`include "partition_counting_sort_defines.svh"

module partition_counting_sort import pcs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PC_W-1:0]      cfg_data_i
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LD_WR  = 8'b0000_0010,
    S_PFX_RD = 8'b0000_0100,
    S_PFX_WR = 8'b0000_1000,
    S_SC_SRC = 8'b0001_0000,
    S_SC_BKT = 8'b0010_0000,
    S_SC_WR  = 8'b0100_0000,
    S_RD     = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [PC_W-1:0]   pc_q;
  logic              gd_q;
  logic [CNT_W-1:0]  rows_q, rows_d;
  logic              batch_done_q, batch_done_d;
  logic              grouped_q, grouped_d;
  logic              last_q, last_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [BKT_AW-1:0] p_q, p_d;
  logic [CNT_W-1:0]  acc_q, acc_d;
  logic [ROW_AW-1:0] r_q, r_d;
  logic [1:0]        rd_func_q, rd_func_d;
  out_t              res_q, res_d;
  logic              res_pend_q, res_pend_d;
  out_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic [PC_W-1:0]   parts;
  logic [CNT_W-1:0]  rows_eff;
  logic              load_ok;
  logic [CNT_W-1:0]  acc_sum;
  logic [CNT_W-1:0]  bkt_dec;

  logic              src_we;
  logic [ROW_AW-1:0] src_waddr, src_raddr;
  logic [ID_W-1:0]   src_wdata, src_rdata;
  logic              grp_we;
  logic [ROW_AW-1:0] grp_waddr, grp_raddr;
  logic [ROW_AW-1:0] grp_wdata, grp_rdata;
  bkt_req_t          bkt_req;
  logic [CNT_W-1:0]  bkt_rdata;

  pcs_ram #(
    .Width(ID_W),
    .Depth(MAX_ROWS)
  ) u_src_ram (
    .clk_i  (clk_i),
    .we_i   (src_we),
    .waddr_i(src_waddr),
    .wdata_i(src_wdata),
    .raddr_i(src_raddr),
    .rdata_o(src_rdata)
  );

  pcs_ram #(
    .Width(ROW_AW),
    .Depth(MAX_ROWS)
  ) u_grp_ram (
    .clk_i  (clk_i),
    .we_i   (grp_we),
    .waddr_i(grp_waddr),
    .wdata_i(grp_wdata),
    .raddr_i(grp_raddr),
    .rdata_o(grp_rdata)
  );

  pcs_bucket u_bucket (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (bkt_req),
    .rdata_o(bkt_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE) && !res_pend_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    if (pc_q == '0) begin
      parts = PC_W'(1);
    end else if (pc_q > PC_W'(MAX_PARTS)) begin
      parts = PC_W'(MAX_PARTS);
    end else begin
      parts = pc_q;
    end
  end

  assign rows_eff = batch_done_q ? '0 : rows_q;
  assign load_ok  = (PC_W'(in_data_i.partition_id) < parts) &&
                    (rows_eff < CNT_W'(MAX_ROWS));
  assign acc_sum  = acc_q + bkt_rdata;
  assign bkt_dec  = bkt_rdata - CNT_W'(1);

  always_comb begin
    state_d      = state_q;
    rows_d       = rows_q;
    batch_done_d = batch_done_q;
    grouped_d    = grouped_q;
    last_d       = last_q;
    id_d         = id_q;
    p_d          = p_q;
    acc_d        = acc_q;
    r_d          = r_q;
    rd_func_d    = rd_func_q;
    res_d        = res_q;
    res_pend_d   = res_pend_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;

    src_we    = 1'b0;
    src_waddr = rows_eff[ROW_AW-1:0];
    src_wdata = in_data_i.partition_id;
    src_raddr = in_data_i.index[ROW_AW-1:0];
    grp_we    = 1'b0;
    grp_waddr = bkt_dec[ROW_AW-1:0];
    grp_wdata = r_q;
    grp_raddr = in_data_i.index[ROW_AW-1:0];
    bkt_req       = '0;
    bkt_req.raddr = in_data_i.index[BKT_AW-1:0];

    // output register refill
    if (res_pend_q && (!out_valid_q || out_ready_i)) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
      res_pend_d  = 1'b0;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          res_pend_d = 1'b1;
          res_d      = '0;
          if (in_data_i.func == FUNC_LOAD) begin
            // a load after a closed batch starts a new one
            bkt_req.clear = batch_done_q;
            rows_d        = rows_eff;
            batch_done_d  = 1'b0;
            grouped_d     = 1'b0;
            last_d        = in_data_i.last_row;
            id_d          = in_data_i.partition_id;
            if (load_ok) begin
              src_we        = 1'b1;
              bkt_req.raddr = BKT_AW'(in_data_i.partition_id);
              rows_d        = rows_eff + CNT_W'(1);
              state_d       = S_LD_WR;
            end else begin
              res_d.status = ST_RANGE;
              if (in_data_i.last_row) begin
                if (gd_q) begin
                  batch_done_d = 1'b1;
                end else begin
                  p_d     = '0;
                  acc_d   = '0;
                  state_d = S_PFX_RD;
                end
              end
            end
          end else if (!batch_done_q) begin
            res_d.status = ST_NA;
          end else begin
            unique case (in_data_i.func)
              FUNC_GROUPED: begin
                if (!grouped_q) begin
                  res_d.status = ST_NA;
                end else if (in_data_i.index >= rows_q) begin
                  res_d.status = ST_RANGE;
                end else begin
                  res_pend_d = 1'b0;
                  rd_func_d  = in_data_i.func;
                  state_d    = S_RD;
                end
              end
              FUNC_START: begin
                if (!grouped_q) begin
                  res_d.status = ST_NA;
                end else if (in_data_i.index > IDX_W'(parts)) begin
                  res_d.status = ST_RANGE;
                end else begin
                  res_pend_d = 1'b0;
                  rd_func_d  = in_data_i.func;
                  state_d    = S_RD;
                end
              end
              FUNC_SOURCE: begin
                if (in_data_i.index >= rows_q) begin
                  res_d.status = ST_RANGE;
                end else begin
                  res_pend_d = 1'b0;
                  rd_func_d  = in_data_i.func;
                  state_d    = S_RD;
                end
              end
              default: begin
                res_d.status = ST_NA;
              end
            endcase
          end
        end
      end
      S_LD_WR: begin
        bkt_req.we    = 1'b1;
        bkt_req.waddr = BKT_AW'(id_q);
        bkt_req.wdata = bkt_rdata + CNT_W'(1);
        if (last_q) begin
          if (gd_q) begin
            batch_done_d = 1'b1;
            state_d      = S_IDLE;
          end else begin
            p_d     = '0;
            acc_d   = '0;
            state_d = S_PFX_RD;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      S_PFX_RD: begin
        bkt_req.raddr = p_q;
        state_d       = S_PFX_WR;
      end
      S_PFX_WR: begin
        bkt_req.we    = 1'b1;
        bkt_req.waddr = p_q;
        bkt_req.wdata = acc_sum;
        acc_d         = acc_sum;
        if (p_q == BKT_AW'(MAX_PARTS)) begin
          if (rows_q == '0) begin
            batch_done_d = 1'b1;
            grouped_d    = 1'b1;
            state_d      = S_IDLE;
          end else begin
            r_d     = ROW_AW'(rows_q - CNT_W'(1));
            state_d = S_SC_SRC;
          end
        end else begin
          p_d     = p_q + BKT_AW'(1);
          state_d = S_PFX_RD;
        end
      end
      S_SC_SRC: begin
        src_raddr = r_q;
        state_d   = S_SC_BKT;
      end
      S_SC_BKT: begin
        bkt_req.raddr = BKT_AW'(src_rdata);
        id_d          = src_rdata;
        state_d       = S_SC_WR;
      end
      S_SC_WR: begin
        if (bkt_rdata != '0) begin
          bkt_req.we    = 1'b1;
          bkt_req.waddr = BKT_AW'(id_q);
          bkt_req.wdata = bkt_dec;
          grp_we        = (bkt_dec < CNT_W'(MAX_ROWS));
        end
        if (r_q == '0) begin
          batch_done_d = 1'b1;
          grouped_d    = 1'b1;
          state_d      = S_IDLE;
        end else begin
          r_d     = r_q - ROW_AW'(1);
          state_d = S_SC_SRC;
        end
      end
      S_RD: begin
        res_pend_d   = 1'b1;
        res_d.status = ST_OK;
        case (rd_func_q)
          FUNC_GROUPED: res_d.value = VAL_W'(grp_rdata);
          FUNC_START:   res_d.value = VAL_W'(bkt_rdata);
          default:      res_d.value = VAL_W'(src_rdata);
        endcase
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pc_q         <= PC_W'(1);
      gd_q         <= 1'b0;
      rows_q       <= '0;
      batch_done_q <= 1'b0;
      grouped_q    <= 1'b0;
      res_pend_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rows_q       <= rows_d;
      batch_done_q <= batch_done_d;
      grouped_q    <= grouped_d;
      res_pend_q   <= res_pend_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_PART_COUNT: pc_q <= cfg_data_i;
          CFG_GROUP_DIS:  gd_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q    <= last_d;
    id_q      <= id_d;
    p_q       <= p_d;
    acc_q     <= acc_d;
    r_q       <= r_d;
    rd_func_q <= rd_func_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  `PCS_ASSERT_IMP(a_grouped_closed, grouped_q, batch_done_q, "grouped flag without closed batch")
  `PCS_ASSERT_IMP(a_err_zero, out_valid_o && out_data_o.status != ST_OK, out_data_o.value == '0, "error item with nonzero value")
  `PCS_ASSERT_NXT(a_item_tracked, in_valid_i && in_ready_o, res_pend_q || state_q != S_IDLE, "accepted item left no result")
  `PCS_ASSERT_IMP(a_rows_bound, 1'b1, rows_q <= CNT_W'(MAX_ROWS), "row count above row store size")

endmodule

/* bench/pcs_sort_checker.sv */
`timescale 1ns / 1ps
// checker of the partition counting sort block: predicts each result item and compares it
module pcs_sort_checker import pcs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_t                  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_t                 out_data_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PC_W-1:0]      cfg_data_i,
  output int unsigned          pending_o,
  output int unsigned          fail_count_o
);

  logic [PC_W-1:0]   part_count_q;
  logic              group_dis_q;
  logic [ID_W-1:0]   src_ids      [MAX_ROWS];
  logic [ROW_AW-1:0] grouped_rows [MAX_ROWS];
  logic [CNT_W-1:0]  buckets      [BKT_DEPTH];
  int unsigned       rows_loaded;
  bit                batch_done;
  bit                batch_grouped;
  out_t              answers_q [$];
  int unsigned       fail_count;

  function automatic int unsigned parts_in_use();
    if (part_count_q == '0) return 1;
    if (part_count_q > MAX_PARTS) return MAX_PARTS;
    return part_count_q;
  endfunction

  function automatic void clear_buckets();
    for (int p = 0; p < BKT_DEPTH; p++) buckets[p] = '0;
  endfunction

  // inclusive prefix over all buckets, then scatter from the last row down
  function automatic void group_batch();
    logic [ID_W-1:0] id;
    for (int p = 1; p < BKT_DEPTH; p++) buckets[p] = buckets[p] + buckets[p-1];
    for (int r = int'(rows_loaded) - 1; r >= 0; r--) begin
      id = src_ids[r];
      if (buckets[id] != '0) begin
        buckets[id] = buckets[id] - 1'b1;
        grouped_rows[buckets[id][ROW_AW-1:0]] = r[ROW_AW-1:0];
      end
    end
    batch_grouped = 1'b1;
  endfunction

  function automatic out_t answer_item(in_t it);
    out_t        res;
    int unsigned parts;
    res.value  = '0;
    res.status = ST_OK;
    parts      = parts_in_use();
    if (it.func == FUNC_LOAD) begin
      if (batch_done) begin
        clear_buckets();
        rows_loaded   = 0;
        batch_done    = 1'b0;
        batch_grouped = 1'b0;
      end
      if (it.partition_id >= parts || rows_loaded >= MAX_ROWS) begin
        res.status = ST_RANGE;
      end else begin
        src_ids[rows_loaded]      = it.partition_id;
        buckets[it.partition_id]  = buckets[it.partition_id] + 1'b1;
        rows_loaded++;
      end
      if (it.last_row) begin
        if (!group_dis_q) group_batch();
        batch_done = 1'b1;
      end
    end else if (!batch_done) begin
      res.status = ST_NA;
    end else begin
      case (it.func)
        FUNC_GROUPED: begin
          if (!batch_grouped) res.status = ST_NA;
          else if (it.index >= rows_loaded) res.status = ST_RANGE;
          else res.value = VAL_W'(grouped_rows[it.index[ROW_AW-1:0]]);
        end
        FUNC_START: begin
          if (!batch_grouped) res.status = ST_NA;
          else if (it.index > parts) res.status = ST_RANGE;
          else res.value = VAL_W'(buckets[it.index[BKT_AW-1:0]]);
        end
        default: begin
          if (it.index >= rows_loaded) res.status = ST_RANGE;
          else res.value = VAL_W'(src_ids[it.index[ROW_AW-1:0]]);
        end
      endcase
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_res;
    if (!rst_ni) begin
      part_count_q  = PC_W'(1);
      group_dis_q   = 1'b0;
      clear_buckets();
      rows_loaded   = 0;
      batch_done    = 1'b0;
      batch_grouped = 1'b0;
      answers_q.delete();
      fail_count    = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (answers_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result item: value %0d status %0d",
                     out_data_i.value, out_data_i.status);
        end else begin
          exp_res = answers_q.pop_front();
          if (out_data_i.value !== exp_res.value || out_data_i.status !== exp_res.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected value %0d status %0d, got value %0d status %0d",
                       exp_res.value, exp_res.status, out_data_i.value, out_data_i.status);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_PART_COUNT) part_count_q = cfg_data_i;
        else group_dis_q = cfg_data_i[0];
      end
      if (in_valid_i && in_ready_i) answers_q.push_back(answer_item(in_data_i));
      pending_o    <= answers_q.size();
      fail_count_o <= fail_count;
    end
  end

endmodule

/* bench/tb_partition_counting_sort.sv */
`timescale 1ns / 1ps
// testbench top of the partition counting sort block: stimulus, idling and verdict
module tb_partition_counting_sort;
  import pcs_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_ITEMS = 1900;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_t                  in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_t                 out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [PC_W-1:0]      cfg_data_i;

  int unsigned pending_results;
  int unsigned fail_total;
  int unsigned idle_cycles;
  int unsigned items_sent;
  int unsigned longest_batch;
  int unsigned cur_parts;
  int unsigned hold_left;
  bit          no_idle;

  always #5 clk_i = ~clk_i;

  partition_counting_sort uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  pcs_sort_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending_results),
    .fail_count_o (fail_total)
  );

  function automatic int unsigned next_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned clamp_parts(logic [PC_W-1:0] val);
    if (val == '0) return 1;
    if (val > MAX_PARTS) return MAX_PARTS;
    return val;
  endfunction

  function automatic in_t load_item(logic [ID_W-1:0] id, logic last);
    in_t it;
    it.func         = FUNC_LOAD;
    it.partition_id = id;
    it.last_row     = last;
    it.index        = IDX_W'($urandom());
    return it;
  endfunction

  function automatic in_t read_item(logic [1:0] func, logic [IDX_W-1:0] idx);
    in_t it;
    it.func         = func;
    it.partition_id = ID_W'($urandom());
    it.last_row     = 1'($urandom());
    it.index        = idx;
    return it;
  endfunction

  // no-accept watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("partition_counting_sort test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side stalls
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
    end else if (no_idle || !out_ready_i) begin
      out_ready_i <= 1'b1;
      hold_left = no_idle ? 0 : $urandom_range(0, 15);
    end else begin
      out_ready_i <= 1'b0;
      hold_left = next_gap();
    end
  end

  task automatic send_item(in_t it);
    int unsigned gap;
    gap = next_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic idle_in();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (pending_results != 0);
  endtask

  // let the grouping pass of the longest batch finish before touching registers
  task automatic quiesce(int unsigned rows);
    int unsigned kept;
    kept = (rows > MAX_ROWS) ? MAX_ROWS : rows;
    idle_in();
    wait_drained();
    repeat (2 * BKT_DEPTH + 3 * kept + 32) @(posedge clk_i);
    longest_batch = 0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PC_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_batch();
    int unsigned rows;
    int unsigned nreads;
    int unsigned r;
    logic [1:0]  func;
    logic [ID_W-1:0] id;
    r = $urandom_range(0, 99);
    if (r < 70) rows = $urandom_range(1, 16);
    else if (r < 95) rows = $urandom_range(17, 64);
    else rows = $urandom_range(65, 300);
    if (rows > longest_batch) longest_batch = rows;
    for (int k = 0; k < rows; k++) begin
      if ($urandom_range(0, 99) < 5)
        send_item(read_item(2'($urandom_range(1, 3)), IDX_W'($urandom())));
      if ($urandom_range(0, 9) == 0) id = ID_W'($urandom());
      else id = ID_W'($urandom_range(0, cur_parts - 1));
      send_item(load_item(id, k == rows - 1));
    end
    nreads = $urandom_range(rows / 2, 2 * rows + 4);
    for (int k = 0; k < nreads; k++) begin
      func = 2'($urandom_range(1, 3));
      if ($urandom_range(0, 4) == 0)
        send_item(read_item(func, IDX_W'($urandom())));
      else if (func == FUNC_START)
        send_item(read_item(func, IDX_W'($urandom_range(0, cur_parts + 1))));
      else
        send_item(read_item(func, IDX_W'($urandom_range(0, rows + 1))));
      if ($urandom_range(0, 99) == 0) begin
        idle_in();
        wait_drained();
      end
    end
  endtask

  initial begin
    int unsigned     phase;
    logic [PC_W-1:0] part_val;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_ready_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_PART_COUNT;
    cfg_data_i    = '0;
    idle_cycles   = 0;
    items_sent    = 0;
    longest_batch = 0;
    hold_left     = 0;
    no_idle       = 1'b0;
    cur_parts     = 1;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reads before any batch
    send_item(read_item(FUNC_GROUPED, '0));
    send_item(read_item(FUNC_START, '0));
    send_item(read_item(FUNC_SOURCE, '0));

    // zero partition count acts as one, out-of-range id dropped
    quiesce(0);
    write_reg(CFG_PART_COUNT, '0);
    cur_parts = 1;
    send_item(load_item(8'd0, 1'b0));
    send_item(load_item(8'd1, 1'b0));
    send_item(load_item(8'd0, 1'b1));
    send_item(read_item(FUNC_GROUPED, 13'd0));
    send_item(read_item(FUNC_GROUPED, 13'd1));
    send_item(read_item(FUNC_GROUPED, 13'd2));
    send_item(read_item(FUNC_GROUPED, 13'h1FFF));
    send_item(read_item(FUNC_START, 13'd0));
    send_item(read_item(FUNC_START, 13'd1));
    send_item(read_item(FUNC_START, 13'd2));
    send_item(read_item(FUNC_SOURCE, 13'd1));
    send_item(read_item(FUNC_SOURCE, 13'h1FFF));

    // count above the maximum clamps, extreme ids
    quiesce(3);
    write_reg(CFG_PART_COUNT, 9'h1FF);
    cur_parts = MAX_PARTS;
    send_item(load_item(8'd255, 1'b0));
    send_item(load_item(8'd0, 1'b0));
    send_item(load_item(8'd255, 1'b0));
    send_item(load_item(8'd128, 1'b1));
    send_item(read_item(FUNC_GROUPED, 13'd3));
    send_item(read_item(FUNC_START, 13'd255));
    send_item(read_item(FUNC_START, 13'd256));
    send_item(read_item(FUNC_START, 13'd257));

    // grouping disabled, last mark on a dropped row
    quiesce(4);
    write_reg(CFG_PART_COUNT, 9'd8);
    write_reg(CFG_GROUP_DIS, 9'h0FF);
    cur_parts = 8;
    send_item(load_item(8'd3, 1'b0));
    send_item(load_item(8'd200, 1'b1));
    send_item(read_item(FUNC_GROUPED, 13'd0));
    send_item(read_item(FUNC_START, 13'd0));
    send_item(read_item(FUNC_SOURCE, 13'd0));
    send_item(read_item(FUNC_SOURCE, 13'd1));

    // random phases, each under its own settings
    items_sent = 0;
    phase      = 0;
    longest_batch = 2;
    while (items_sent < RANDOM_ITEMS) begin
      quiesce(longest_batch);
      case (phase % 6)
        0:       part_val = PC_W'(MAX_PARTS);
        1:       part_val = PC_W'(1);
        2:       part_val = '0;
        3:       part_val = PC_W'($urandom_range(MAX_PARTS + 1, 511));
        default: part_val = PC_W'($urandom_range(2, MAX_PARTS - 1));
      endcase
      write_reg(CFG_PART_COUNT, part_val);
      cur_parts = clamp_parts(part_val);
      write_reg(CFG_GROUP_DIS, {8'($urandom()), 1'($urandom_range(0, 4) == 0)});
      no_idle = (phase % 4 == 3);
      repeat (4) random_batch();
      phase++;
    end

    quiesce(longest_batch);
    if (fail_total == 0) begin
      $display("partition_counting_sort test passed");
    end else begin
      $display("partition_counting_sort test failed");
    end
    $finish;
  end

endmodule
